/* rtl/sorted_timestamp_bookmark_set_macros.svh */
// Assertion macros for the sorted timestamp bookmark set.
// Used by rtl/sorted_timestamp_bookmark_set.sv; expect clk and arst_n in scope.
`ifndef SORTED_TIMESTAMP_BOOKMARK_SET_MACROS_SVH
`define SORTED_TIMESTAMP_BOOKMARK_SET_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define STBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds.
`define STBS_NEVER(lbl, cond, msg) \
	`STBS_ASSERT(lbl, !(cond), msg)
`else
`define STBS_ASSERT(lbl, prop, msg)
`define STBS_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/stbs_pkg.sv */
// Package for the sorted timestamp bookmark set: command and result word types,
// command and status codes. No dependencies.
`default_nettype none
package stbs_pkg;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_DEL   = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_NEXT  = 3'd3;
	localparam logic [2:0] OP_PREV  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	typedef struct packed {
		logic        [2:0]  op;
		logic signed [31:0] query_time;
	} cmd_t;

	typedef struct packed {
		logic        [2:0]  status;
		logic signed [31:0] result_time;
		logic        [6:0]  entry_count;
	} rsp_t;

endpackage
`default_nettype wire

/* rtl/sorted_timestamp_bookmark_set.sv */
// Sorted timestamp bookmark set: table memory, scan/shift sequencer, result register.
// Depends on stbs_pkg and sorted_timestamp_bookmark_set_macros.svh.
`default_nettype none
`include "sorted_timestamp_bookmark_set_macros.svh"

// Keeps up to MAX_ENTRIES unique signed 32-bit timestamps in ascending order in a
// single-port-write, single-port-read table memory with a registered read. Commands
// arrive on the cmd channel (add, delete, clear, next, prev) and each one returns
// exactly one rsp word with a status, a found time (zero unless next/prev succeed)
// and the count after the command. A command is taken only while the sequencer is
// idle; cmd_stall is high for the whole of its work. Every add, delete,
// next and prev first scans all stored entries through the one read port, comparing
// each word with the query as signed values. Add then moves the entries above the
// insert point up by one, one per cycle, and writes the new time; delete moves the
// entries above the match down by one; next/prev make one more read. Clear and
// unused codes go straight to the result step. The result waits in an output
// register, so the next command can be taken while it is unread; the block only
// holds its final step if the previous result is still stalled.
// The table needs no clearing after reset: only entries below the count are read.
module sorted_timestamp_bookmark_set #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_stall,
	input  wire stbs_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output stbs_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_MOVE, S_FETCH, S_FWAIT, S_DONE
	} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	logic signed [31:0] query_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;      // scan index, move pointer or fetch index
	logic [CW-1:0]      lt_q;       // entries below the query
	logic [CW-1:0]      le_q;       // entries not above the query
	logic               eq_q;
	logic               pend_q;     // rdata_q holds the word just read
	logic [AW-1:0]      wa_q;       // write address for the pending word
	logic [2:0]         status_q;
	logic signed [31:0] res_q;

	// Table memory
	logic signed [31:0] mem [MAX_ENTRIES];
	logic signed [31:0] rdata_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	logic [CW-1:0] ptr_m1;
	logic [CW-1:0] ptr_p1;
	logic [CW-1:0] anchor;
	logic [CW-1:0] anchor_p1;
	logic [CW-1:0] anchor_m1;
	logic          slot_free;
	logic          cmd_acc;
	logic [CW+6:0] cnt_ext;

	assign ptr_m1    = ptr_q - CW'(1);
	assign ptr_p1    = ptr_q + CW'(1);
	// Anchor: last entry not above the query, else the first entry
	assign anchor    = (le_q == '0) ? '0 : le_q - CW'(1);
	assign anchor_p1 = anchor + CW'(1);
	assign anchor_m1 = anchor - CW'(1);
	assign slot_free = !rsp_valid || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cnt_ext   = {7'd0, count_q};

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = wa_q;
		wr_data = rdata_q;
		unique case (state_q)
			S_SCAN: begin
				rd_en = (ptr_q != count_q);
			end
			S_MOVE: begin
				if (op_q == stbs_pkg::OP_ADD) begin
					// Walk down from the top, moving each word up one place
					rd_en   = (ptr_q != lt_q);
					rd_addr = ptr_m1[AW-1:0];
					wr_en   = pend_q;
					if (ptr_q == lt_q && !pend_q) begin
						wr_en   = 1'b1;
						wr_addr = lt_q[AW-1:0];
						wr_data = query_q;
					end
				end else begin
					// Walk up from above the match, moving each word down
					rd_en = (ptr_q != count_q);
					wr_en = pend_q;
				end
			end
			S_FETCH: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= '0;
			query_q   <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			lt_q      <= '0;
			le_q      <= '0;
			eq_q      <= 1'b0;
			pend_q    <= 1'b0;
			wa_q      <= '0;
			status_q  <= stbs_pkg::ST_OK;
			res_q     <= '0;
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else begin
			// Raise valid as a result leaves the sequencer; drop it once the word is taken
			if (state_q == S_DONE && slot_free) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						op_q     <= cmd.op;
						query_q  <= cmd.query_time;
						status_q <= stbs_pkg::ST_OK;
						res_q    <= '0;
						ptr_q    <= '0;
						lt_q     <= '0;
						le_q     <= '0;
						eq_q     <= 1'b0;
						pend_q   <= 1'b0;
						case (cmd.op) inside
							stbs_pkg::OP_ADD, stbs_pkg::OP_DEL, stbs_pkg::OP_NEXT,
							stbs_pkg::OP_PREV: begin
								state_q <= S_SCAN;
							end
							stbs_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Issue one read a cycle; compare the word that arrives
					pend_q <= (ptr_q != count_q);
					if (ptr_q != count_q) begin
						ptr_q <= ptr_p1;
					end
					if (pend_q) begin
						if (rdata_q < query_q) begin
							lt_q <= lt_q + CW'(1);
						end
						if (rdata_q <= query_q) begin
							le_q <= le_q + CW'(1);
						end
						if (rdata_q == query_q) begin
							eq_q <= 1'b1;
						end
					end
					if (ptr_q == count_q && !pend_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					pend_q <= 1'b0;
					unique case (op_q)
						stbs_pkg::OP_ADD: begin
							if (eq_q) begin
								status_q <= stbs_pkg::ST_PRESENT;
								state_q  <= S_DONE;
							end else if (count_q >= CW'(MAX_ENTRIES)) begin
								status_q <= stbs_pkg::ST_FULL;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= count_q;
								state_q <= S_MOVE;
							end
						end
						stbs_pkg::OP_DEL: begin
							if (!eq_q) begin
								status_q <= stbs_pkg::ST_NOT_FOUND;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= lt_q + CW'(1);
								state_q <= S_MOVE;
							end
						end
						default: begin
							if (count_q == '0) begin
								status_q <= stbs_pkg::ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								if (op_q == stbs_pkg::OP_NEXT) begin
									ptr_q <= (anchor_p1 < count_q) ? anchor_p1 : anchor;
								end else begin
									ptr_q <= (anchor != '0) ? anchor_m1 : anchor;
								end
								state_q <= S_FETCH;
							end
						end
					endcase
				end
				S_MOVE: begin
					if (op_q == stbs_pkg::OP_ADD) begin
						pend_q <= (ptr_q != lt_q);
						if (ptr_q != lt_q) begin
							ptr_q <= ptr_m1;
							wa_q  <= ptr_q[AW-1:0];
						end
						if (ptr_q == lt_q && !pend_q) begin
							count_q <= count_q + CW'(1);
							state_q <= S_DONE;
						end
					end else begin
						pend_q <= (ptr_q != count_q);
						if (ptr_q != count_q) begin
							ptr_q <= ptr_p1;
							wa_q  <= ptr_m1[AW-1:0];
						end
						if (ptr_q == count_q && !pend_q) begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					res_q   <= rdata_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hold until the result register is free
					if (slot_free) begin
						rsp.status      <= status_q;
						rsp.result_time <= res_q;
						rsp.entry_count <= cnt_ext[6:0];
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`STBS_NEVER(a_count_bound, count_q > CW'(MAX_ENTRIES), "entry count above depth")
	`STBS_ASSERT(a_busy_after_accept, cmd_acc |=> state_q != S_IDLE, "command not started")
	`STBS_ASSERT(a_add_ptr_floor, (state_q == S_MOVE && op_q == stbs_pkg::OP_ADD) |-> ptr_q >= lt_q, "insert shift went below insert point")
	`STBS_ASSERT(a_empty_count, (rsp_valid && rsp.status == stbs_pkg::ST_EMPTY) |-> (rsp.entry_count == 7'd0 && rsp.result_time == 32'sd0), "empty status with entries")

endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_timestamp_bookmark_set: a directed table, then phased
// random commands; each response checked against a pinned word or a sorted shadow set.
// Depends on stbs_pkg and the RTL of sorted_timestamp_bookmark_set.

module testbench;

	localparam int unsigned DEPTH        = 64;
	localparam int unsigned HALF_PERIOD  = 5;
	localparam int unsigned RESET_CYCLES = 8;
	localparam int unsigned IDLE_PCT     = 37;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned TAIL_CYCLES  = 300;
	localparam int unsigned LIMIT_CYCLES = 800_000;
	localparam int unsigned SHOWN_FAULTS = 10;

	// Command codes the block ignores.
	localparam logic [2:0] OP_RSVD_LO  = 3'd5;
	localparam logic [2:0] OP_RSVD_MID = 3'd6;
	localparam logic [2:0] OP_RSVD_HI  = 3'd7;

	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BLEND} op_mix_t;

	// One row of the directed table: the command word and, where it is obvious,
	// the response pinned by hand.
	typedef struct {
		stbs_pkg::cmd_t word;
		bit             pinned;
		stbs_pkg::rsp_t want;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	stbs_pkg::cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	stbs_pkg::rsp_t rsp;

	// Shadow copy of the bookmark set, updated as each command word is taken.
	logic signed [31:0] shadow_marks [DEPTH];
	int unsigned shadow_count = 0;

	stbs_pkg::rsp_t pending_outcomes [$];
	probe_t script [$];
	int unsigned fault_count = 0;
	int unsigned rsp_seen = 0;

	// Handshake between the command driver and the response sink.
	bit cmd_quiet = 1'b0;
	bit rsp_quiet = 1'b0;
	bit hold_wanted = 1'b0;

	sorted_timestamp_bookmark_set #(.MAX_ENTRIES(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	// Greatest entry not above t, or the first entry if all are later.
	// Only called with a non-empty set.
	function automatic int unsigned anchor_index(input logic signed [31:0] t);
		int unsigned i;
		i = 0;
		while (i + 1 < shadow_count && shadow_marks[i + 1] <= t)
			i++;
		return i;
	endfunction

	// Apply one command to the shadow set and return the response it must produce.
	function automatic stbs_pkg::rsp_t bookmark_outcome(input stbs_pkg::cmd_t c);
		stbs_pkg::rsp_t r;
		int unsigned k;
		int unsigned a;
		r.status = stbs_pkg::ST_OK;
		r.result_time = '0;
		case (c.op) inside
			stbs_pkg::OP_ADD: begin
				// insert point is the number of entries below the new time
				k = 0;
				while (k < shadow_count && shadow_marks[k] < c.query_time)
					k++;
				if (k < shadow_count && shadow_marks[k] == c.query_time) begin
					r.status = stbs_pkg::ST_PRESENT;
				end else if (shadow_count >= DEPTH) begin
					r.status = stbs_pkg::ST_FULL;
				end else begin
					for (a = shadow_count; a > k; a--)
						shadow_marks[a] = shadow_marks[a - 1];
					shadow_marks[k] = c.query_time;
					shadow_count++;
				end
			end
			stbs_pkg::OP_DEL: begin
				if (shadow_count == 0) begin
					r.status = stbs_pkg::ST_NOT_FOUND;
				end else begin
					a = anchor_index(c.query_time);
					if (shadow_marks[a] != c.query_time) begin
						r.status = stbs_pkg::ST_NOT_FOUND;
					end else begin
						for (k = a; k + 1 < shadow_count; k++)
							shadow_marks[k] = shadow_marks[k + 1];
						shadow_count--;
					end
				end
			end
			stbs_pkg::OP_CLEAR: begin
				shadow_count = 0;
			end
			stbs_pkg::OP_NEXT, stbs_pkg::OP_PREV: begin
				if (shadow_count == 0) begin
					r.status = stbs_pkg::ST_EMPTY;
				end else begin
					a = anchor_index(c.query_time);
					// stay on the anchor when it sits at that end of the table
					if (c.op == stbs_pkg::OP_NEXT) begin
						if (a + 1 < shadow_count)
							a++;
					end else if (a > 0) begin
						a--;
					end
					r.result_time = shadow_marks[a];
				end
			end
			default: ;
		endcase
		r.entry_count = 7'(shadow_count);
		return r;
	endfunction

	// Draw an op code; the mix decides whether the set tends to grow or shrink.
	function automatic logic [2:0] pick_op(input op_mix_t mix);
		int unsigned r;
		int unsigned cut [5];
		r = $urandom_range(0, 99);
		// cumulative percentages for add, delete, clear, next, prev; the rest is unused codes
		case (mix)
			MIX_FILL:  cut = '{75, 80, 80, 89, 98};
			MIX_DRAIN: cut = '{15, 70, 73, 85, 97};
			default:   cut = '{35, 60, 63, 80, 97};
		endcase
		if (r < cut[0])
			return stbs_pkg::OP_ADD;
		if (r < cut[1])
			return stbs_pkg::OP_DEL;
		if (r < cut[2])
			return stbs_pkg::OP_CLEAR;
		if (r < cut[3])
			return stbs_pkg::OP_NEXT;
		if (r < cut[4])
			return stbs_pkg::OP_PREV;
		return 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
	endfunction

	// Draw a time: often a stored one or its neighbour so that hits, duplicates and
	// exact deletes are common; otherwise an extreme, a small value or any 32-bit value.
	function automatic logic signed [31:0] pick_time(input bit fresh);
		int unsigned r;
		int unsigned idx;
		r = $urandom_range(0, 99);
		if (shadow_count != 0 && r < (fresh ? 15 : 45)) begin
			idx = $urandom_range(0, shadow_count - 1);
			return shadow_marks[idx];
		end
		if (shadow_count != 0 && r < (fresh ? 25 : 60)) begin
			idx = $urandom_range(0, shadow_count - 1);
			return shadow_marks[idx] + (($urandom_range(0, 1) == 0) ? 32'sd1 : -32'sd1);
		end
		if (r < 75) begin
			case ($urandom_range(0, 5))
				0:       return T_MIN;
				1:       return T_MAX;
				2:       return 32'sd0;
				3:       return -32'sd1;
				4:       return 32'sd1;
				default: return 32'($urandom_range(0, 200)) - 32'sd100;
			endcase
		end
		return $urandom();
	endfunction

	task automatic flag_fault(input string what);
		fault_count++;
		if (fault_count <= SHOWN_FAULTS)
			$display("%0t: %s", $time, what);
	endtask

	// Offer one command word. Enter and leave at a falling edge; valid is written
	// once per edge, so a back-to-back word keeps it high without a glitch.
	task automatic send_word(input stbs_pkg::cmd_t word, input bit pinned,
			input stbs_pkg::rsp_t pinned_rsp);
		stbs_pkg::rsp_t predicted;
		while (!cmd_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= word;
		@(posedge clk);
		while (cmd_stall !== 1'b0)
			@(posedge clk);
		// taken: advance the shadow set and queue what must come back
		predicted = bookmark_outcome(word);
		pending_outcomes.push_back(pinned ? pinned_rsp : predicted);
		@(negedge clk);
	endtask

	// Drop valid and hold the sender until every queued response has arrived.
	// Always advance at least one edge so valid is not written twice in one step.
	task automatic drain_outcomes();
		cmd_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_outcomes.size() != 0);
	endtask

	task automatic plan_pinned(input logic [2:0] op, input logic signed [31:0] t,
			input logic [2:0] st, input logic signed [31:0] rt, input logic [6:0] cnt);
		probe_t p;
		p.word = '{op: op, query_time: t};
		p.pinned = 1'b1;
		p.want = '{status: st, result_time: rt, entry_count: cnt};
		script.push_back(p);
	endtask

	task automatic plan_free(input logic [2:0] op, input logic signed [31:0] t);
		probe_t p;
		p.word = '{op: op, query_time: t};
		p.pinned = 1'b0;
		p.want = '0;
		script.push_back(p);
	endtask

	// One random phase: settle the block, set the idling style, then fire off words.
	task automatic run_phase(input op_mix_t mix, input int unsigned words,
			input bit quiet, input bit hold);
		stbs_pkg::cmd_t c;
		drain_outcomes();
		cmd_quiet = quiet;
		rsp_quiet = quiet;
		// a long receiver hold while words keep coming fills the block and stalls its input
		if (hold)
			hold_wanted = 1'b1;
		repeat (words) begin
			c.op = pick_op(mix);
			c.query_time = pick_time(mix == MIX_FILL);
			send_word(c, 1'b0, '0);
		end
	endtask

	// Response sink: random stalls, a quiet stretch on request, and one long hold
	// counted out here in cycles.
	initial begin : response_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (rsp_quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Compare each taken response word with the oldest outstanding expectation.
	always @(posedge clk) begin : response_check
		stbs_pkg::rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			rsp_seen++;
			if (pending_outcomes.size() == 0) begin
				flag_fault($sformatf("response %0d arrived with nothing outstanding: %0d %0d %0d",
					rsp_seen, rsp.status, rsp.result_time, rsp.entry_count));
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp.status !== want.status || rsp.result_time !== want.result_time
						|| rsp.entry_count !== want.entry_count)
					flag_fault($sformatf({"response %0d: expected status %0d time %0d count %0d,",
						" got status %0d time %0d count %0d"}, rsp_seen, want.status,
						want.result_time, want.entry_count, rsp.status, rsp.result_time,
						rsp.entry_count));
			end
		end
	end

	initial begin : stimulus
		// Hold reset, then release it clear of the rising edge.
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty set, ends of the range, duplicates, misses, anchor at
		// either end, every op, unused codes, clear.
		plan_pinned(stbs_pkg::OP_NEXT, 32'sd0, stbs_pkg::ST_EMPTY, 32'sd0, 7'd0);
		plan_pinned(stbs_pkg::OP_PREV, T_MAX, stbs_pkg::ST_EMPTY, 32'sd0, 7'd0);
		plan_pinned(stbs_pkg::OP_DEL, 32'sd5, stbs_pkg::ST_NOT_FOUND, 32'sd0, 7'd0);
		plan_pinned(stbs_pkg::OP_ADD, 32'sd0, stbs_pkg::ST_OK, 32'sd0, 7'd1);
		plan_pinned(stbs_pkg::OP_ADD, T_MIN, stbs_pkg::ST_OK, 32'sd0, 7'd2);
		plan_pinned(stbs_pkg::OP_ADD, T_MAX, stbs_pkg::ST_OK, 32'sd0, 7'd3);
		plan_pinned(stbs_pkg::OP_ADD, 32'sd0, stbs_pkg::ST_PRESENT, 32'sd0, 7'd3);
		plan_free(stbs_pkg::OP_ADD, -32'sd1);
		plan_free(stbs_pkg::OP_ADD, 32'sd1);
		plan_free(stbs_pkg::OP_NEXT, T_MIN);
		plan_free(stbs_pkg::OP_PREV, T_MIN);
		plan_free(stbs_pkg::OP_NEXT, T_MAX);
		plan_free(stbs_pkg::OP_PREV, T_MAX);
		plan_free(stbs_pkg::OP_NEXT, -32'sd5);
		plan_free(stbs_pkg::OP_PREV, 32'sd0);
		plan_pinned(stbs_pkg::OP_DEL, 32'sd7, stbs_pkg::ST_NOT_FOUND, 32'sd0, 7'd5);
		plan_free(stbs_pkg::OP_DEL, T_MIN);
		plan_free(stbs_pkg::OP_DEL, T_MAX);
		plan_free(OP_RSVD_LO, 32'sh5555_5555);
		plan_free(OP_RSVD_MID, 32'shAAAA_AAAA);
		plan_free(OP_RSVD_HI, -32'sd1);
		plan_pinned(stbs_pkg::OP_CLEAR, 32'sd0, stbs_pkg::ST_OK, 32'sd0, 7'd0);
		plan_pinned(stbs_pkg::OP_NEXT, 32'sd0, stbs_pkg::ST_EMPTY, 32'sd0, 7'd0);
		// single entry later than the query: the anchor is that entry itself
		plan_free(stbs_pkg::OP_ADD, 32'sd100);
		plan_free(stbs_pkg::OP_PREV, -32'sd100);
		foreach (script[i])
			send_word(script[i].word, script[i].pinned, script[i].want);

		// Random part: fill to capacity, hold the receiver, drain, run quiet, refill.
		run_phase(MIX_FILL, 150, 1'b0, 1'b0);
		run_phase(MIX_BLEND, 120, 1'b0, 1'b1);
		run_phase(MIX_DRAIN, 120, 1'b0, 1'b0);
		run_phase(MIX_BLEND, 120, 1'b1, 1'b0);
		run_phase(MIX_FILL, 90, 1'b0, 1'b0);

		// Stop offering, wait for the last responses, then watch for strays.
		cmd_valid <= 1'b0;
		cmd_quiet = 1'b0;
		rsp_quiet = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_outcomes.size() == 0)
			$display("sorted_timestamp_bookmark_set verification clean");
		else
			$display("sorted_timestamp_bookmark_set verification failed");
		$finish;
	end

	// Give up well beyond the slowest correct run.
	initial begin : watchdog
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("sorted_timestamp_bookmark_set verification failed");
		$finish;
	end

endmodule
